[rtl/core/tli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and codes of the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  // Command carried in the input tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  // Register indexes (byte address bit 2).
  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_EVEN  = 1'b1;

  // Divider width: magnitude of a 33 by 33 bit product.
  localparam int DivW = 65;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BS_RD,
    S_BS_CMP,
    S_EV_RD0,
    S_EV_RD1,
    S_EV_MUL,
    S_EV_DIV,
    S_EV_FIN,
    S_SEG_RD0,
    S_SEG_RD1,
    S_SEG_CAP,
    S_CALC,
    S_VAL_LD,
    S_VAL_DIV,
    S_VAL_FIN,
    S_SLP_DIV,
    S_SLP_FIN,
    S_OUT
  } state_e;

endpackage

[rtl/core/tli_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/table_linear_interpolator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_interpolator_unit
// Piecewise linear interpolation over a loaded table of Q16.16 points.
// ----------------------------------------------------------------------------
// A load beat writes one abscissa/ordinate pair. An evaluate beat with binary
// search runs a read state and a compare state per search step, then the segment
// reads, then two passes through the bit-serial divider for value and slope;
// with even spacing a third divider pass computes the index in place of the
// search. The input is taken only while the sequencer is idle; a finished
// result waits in the output register while the next beat is accepted.
module table_linear_interpolator_unit
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: entry_index[5:0], entry_abscissa[37:6], entry_ordinate[69:38],
  //        query_x[101:70], zero pad[103:102]
  input  logic [103:0] s_tdata,
  // tuser: cmd[0]
  input  logic         s_tuser,
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: interp_value[31:0], segment_slope[63:32], status[65:64],
  //        zero pad[71:66]
  output logic [71:0]  m_tdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = AW + 2;

  // Input fields.
  logic        [5:0]  in_index;
  logic signed [31:0] in_abs, in_ord, in_x;
  assign in_index = s_tdata[5:0];
  assign in_abs   = s_tdata[37:6];
  assign in_ord   = s_tdata[69:38];
  assign in_x     = s_tdata[101:70];

  // Configuration registers.
  logic [6:0] cfg_count_q;
  logic       cfg_even_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= 7'd2;
      cfg_even_q  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COUNT) begin
        cfg_count_q <= pwdata[6:0];
      end else begin
        cfg_even_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COUNT) ? {25'd0, cfg_count_q} : {31'd0, cfg_even_q};

  // State and datapath registers.
  state_e state_q, state_d;
  logic signed [31:0] x_q, x0_q, f0_q;
  logic signed [32:0] dx_q, df_q, off_q;
  logic        [AW-1:0] last_q, idx_q;
  logic signed [IW-1:0] lo_q, hi_q, mid_q;
  logic        [DivW-1:0] prod_q;
  logic        [DivW-1:0] div_num_q;
  logic        [33:0]     div_rem_q;
  logic        [32:0]     div_den_q;
  logic        [6:0]      div_cnt_q;
  logic                   neg_q;
  logic signed [31:0]     val_q;
  logic                   sat_q;
  logic signed [31:0]     res_val_q, res_slp_q;
  logic        [1:0]      res_st_q;
  logic                   out_valid_q;
  logic        [71:0]     out_data_q;

  // Memories.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic signed [31:0] rd_x, rd_f;

  assign ram_we    = s_tvalid && s_tready && (s_tuser == CMD_LOAD) &&
                     (32'(in_index) < 32'(TABLE_DEPTH));
  assign ram_waddr = AW'(in_index);

  tli_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_abs_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_abs),
    .raddr_i (ram_raddr),
    .rdata_o (rd_x)
  );

  tli_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_ord),
    .raddr_i (ram_raddr),
    .rdata_o (rd_f)
  );

  // Last index in use, with the count clamped to 2..TABLE_DEPTH.
  logic [AW-1:0] last_cfg;
  always_comb begin
    if (32'(cfg_count_q) > 32'(TABLE_DEPTH)) begin
      last_cfg = AW'(TABLE_DEPTH - 1);
    end else if (cfg_count_q < 7'd2) begin
      last_cfg = AW'(1);
    end else begin
      last_cfg = AW'(cfg_count_q - 7'd1);
    end
  end

  // Bisection step.
  logic signed [IW:0]   bs_sum;
  logic signed [IW-1:0] bs_mid, bs_lo, bs_hi;
  logic signed [IW:0]   bs_gap;
  logic [AW-1:0]        bs_idx;
  assign bs_sum = {lo_q[IW-1], lo_q} + {hi_q[IW-1], hi_q};
  assign bs_mid = bs_sum[IW:1];
  always_comb begin
    if ($signed(x_q) >= rd_x) begin
      bs_lo = mid_q;
      bs_hi = hi_q;
    end else begin
      bs_lo = lo_q;
      bs_hi = mid_q;
    end
    bs_gap = {bs_hi[IW-1], bs_hi} - {bs_lo[IW-1], bs_lo};
    if (bs_lo[IW-1]) begin
      bs_idx = '0;
    end else if (bs_lo >= $signed({2'b00, last_q})) begin
      bs_idx = last_q - AW'(1);
    end else begin
      bs_idx = bs_lo[AW-1:0];
    end
  end

  // Even spacing index setup: (x - x0) * last over (xlast - x0).
  logic signed [32:0] ev_off, ev_den;
  logic        [32:0] ev_off_mag, ev_den_mag;
  logic        [32+AW:0] ev_prod;
  assign ev_off     = {x_q[31], x_q} - {x0_q[31], x0_q};
  assign ev_den     = {rd_x[31], rd_x} - {x0_q[31], x0_q};
  assign ev_off_mag = ev_off[32] ? 33'(-ev_off) : 33'(ev_off);
  assign ev_den_mag = ev_den[32] ? 33'(-ev_den) : 33'(ev_den);
  assign ev_prod    = ev_off_mag * last_q;

  // Even spacing index from the quotient, clamped to 0..last-1.
  logic [AW-1:0] ev_idx;
  always_comb begin
    if (neg_q) begin
      ev_idx = '0;
    end else if (div_num_q >= DivW'(last_q)) begin
      ev_idx = last_q - AW'(1);
    end else begin
      ev_idx = div_num_q[AW-1:0];
    end
  end

  // Segment differences and magnitudes.
  logic signed [32:0] seg_dx, seg_df, seg_off;
  logic        [32:0] df_mag, dx_mag, off_mag;
  logic        [65:0] val_prod;
  assign seg_dx   = {rd_x[31], rd_x} - {x0_q[31], x0_q};
  assign seg_df   = {rd_f[31], rd_f} - {f0_q[31], f0_q};
  assign seg_off  = {x_q[31], x_q} - {x0_q[31], x0_q};
  assign df_mag   = df_q[32] ? 33'(-df_q) : 33'(df_q);
  assign dx_mag   = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign off_mag  = off_q[32] ? 33'(-off_q) : 33'(off_q);
  assign val_prod = df_mag * off_mag;

  // Interpolated value: f0 plus the clamped signed quotient, saturated.
  logic        [33:0]     val_qc;
  logic signed [35:0]     val_sq, val_sum;
  logic signed [31:0]     val_sat;
  logic                   val_ovf;
  always_comb begin
    val_qc  = (div_num_q > (DivW'(1) << 33)) ? (34'd1 << 33) : div_num_q[33:0];
    val_sq  = neg_q ? -$signed({2'b00, val_qc}) : $signed({2'b00, val_qc});
    val_sum = 36'(f0_q) + val_sq;
    val_ovf = 1'b0;
    val_sat = val_sum[31:0];
    if (val_sum > 36'sd2147483647) begin
      val_ovf = 1'b1;
      val_sat = 32'sh7fffffff;
    end else if (val_sum < -36'sd2147483648) begin
      val_ovf = 1'b1;
      val_sat = 32'sh80000000;
    end
  end

  // Slope from its quotient, saturated.
  logic signed [31:0] slp_sat;
  logic               slp_ovf;
  always_comb begin
    slp_ovf = 1'b0;
    slp_sat = neg_q ? -$signed(div_num_q[31:0]) : $signed(div_num_q[31:0]);
    if (!neg_q && (div_num_q > DivW'(32'h7fffffff))) begin
      slp_ovf = 1'b1;
      slp_sat = 32'sh7fffffff;
    end else if (neg_q && (div_num_q > DivW'(33'h080000000))) begin
      slp_ovf = 1'b1;
      slp_sat = 32'sh80000000;
    end
  end

  // Restoring divider step, one quotient bit per cycle.
  logic [33:0] div_sh;
  logic        div_ge;
  assign div_sh = {div_rem_q[32:0], div_num_q[DivW-1]};
  assign div_ge = div_sh >= {1'b0, div_den_q};

  // Sequencer: next state, read address and handshake.
  always_comb begin
    state_d   = state_q;
    ram_raddr = '0;
    s_tready  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && (s_tuser == CMD_EVAL)) begin
          state_d = cfg_even_q ? S_EV_RD0 : S_BS_RD;
        end
      end
      S_BS_RD: begin
        ram_raddr = bs_mid[AW-1:0];
        state_d   = S_BS_CMP;
      end
      S_BS_CMP: begin
        state_d = (bs_gap > 1) ? S_BS_RD : S_SEG_RD0;
      end
      S_EV_RD0: begin
        state_d = S_EV_RD1;
      end
      S_EV_RD1: begin
        ram_raddr = last_q;
        state_d   = S_EV_MUL;
      end
      S_EV_MUL: begin
        state_d = (ev_den == '0) ? S_SEG_RD0 : S_EV_DIV;
      end
      S_EV_DIV: begin
        if (div_cnt_q == 7'(DivW - 1)) state_d = S_EV_FIN;
      end
      S_EV_FIN: begin
        state_d = S_SEG_RD0;
      end
      S_SEG_RD0: begin
        ram_raddr = idx_q;
        state_d   = S_SEG_RD1;
      end
      S_SEG_RD1: begin
        ram_raddr = idx_q + AW'(1);
        state_d   = S_SEG_CAP;
      end
      S_SEG_CAP: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        state_d = (dx_q == '0) ? S_OUT : S_VAL_LD;
      end
      S_VAL_LD: begin
        state_d = S_VAL_DIV;
      end
      S_VAL_DIV: begin
        if (div_cnt_q == 7'(DivW - 1)) state_d = S_VAL_FIN;
      end
      S_VAL_FIN: begin
        state_d = S_SLP_DIV;
      end
      S_SLP_DIV: begin
        if (div_cnt_q == 7'(DivW - 1)) state_d = S_SLP_FIN;
      end
      S_SLP_FIN: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_tready) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers, loaded as the sequencer steps.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q    <= in_x;
        last_q <= last_cfg;
        lo_q   <= '1;
        hi_q   <= IW'(last_cfg) + IW'(1);
      end
      S_BS_RD: begin
        mid_q <= bs_mid;
      end
      S_BS_CMP: begin
        lo_q  <= bs_lo;
        hi_q  <= bs_hi;
        idx_q <= bs_idx;
      end
      S_EV_RD1: begin
        x0_q <= rd_x;
      end
      S_EV_MUL: begin
        idx_q     <= '0;
        neg_q     <= ev_off[32] ^ ev_den[32];
        div_num_q <= DivW'(ev_prod);
        div_den_q <= ev_den_mag;
        div_rem_q <= '0;
        div_cnt_q <= '0;
      end
      S_EV_FIN: begin
        idx_q <= ev_idx;
      end
      S_SEG_RD1: begin
        x0_q <= rd_x;
        f0_q <= rd_f;
      end
      S_SEG_CAP: begin
        dx_q  <= seg_dx;
        df_q  <= seg_df;
        off_q <= seg_off;
      end
      S_CALC: begin
        prod_q    <= val_prod[DivW-1:0];
        res_val_q <= f0_q;
        res_slp_q <= '0;
        res_st_q  <= STATUS_ZERO;
      end
      S_VAL_LD: begin
        neg_q     <= df_q[32] ^ off_q[32] ^ dx_q[32];
        div_num_q <= prod_q;
        div_den_q <= dx_mag;
        div_rem_q <= '0;
        div_cnt_q <= '0;
      end
      S_EV_DIV, S_VAL_DIV, S_SLP_DIV: begin
        div_rem_q <= div_ge ? (div_sh - {1'b0, div_den_q}) : div_sh;
        div_num_q <= {div_num_q[DivW-2:0], div_ge};
        div_cnt_q <= div_cnt_q + 7'd1;
      end
      S_VAL_FIN: begin
        val_q     <= val_sat;
        sat_q     <= val_ovf;
        neg_q     <= df_q[32] ^ dx_q[32];
        div_num_q <= DivW'({df_mag, 16'd0});
        div_den_q <= dx_mag;
        div_rem_q <= '0;
        div_cnt_q <= '0;
      end
      S_SLP_FIN: begin
        res_val_q <= val_q;
        res_slp_q <= slp_sat;
        res_st_q  <= (sat_q || slp_ovf) ? STATUS_SAT : STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  logic out_load;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {6'd0, res_st_q, res_slp_q, res_val_q};
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;

endmodule

[rtl/core/tli_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_checker
// Port-level checks of the table linear interpolator.
// ----------------------------------------------------------------------------
module tli_checker
  import tli_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         pready,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [71:0]  m_tdata
);

  // A result beat stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped before it was taken");

  // Only the three defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[65:64] == STATUS_OK) || (m_tdata[65:64] == STATUS_ZERO) ||
                 (m_tdata[65:64] == STATUS_SAT))
    else $error("undefined status code");

  // A zero-width interval reports a zero slope.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tdata[65:64] == STATUS_ZERO) |-> (m_tdata[63:32] == 32'd0))
    else $error("zero-width interval with nonzero slope");

  // A load beat never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && (s_tuser == CMD_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("result appeared after a load beat");

  // The configuration port never waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind table_linear_interpolator_unit tli_checker u_tli_checker (.*);
